// ----- design/spte_pkg.sv -----
// Package for the sparse projection top-K encoder: sizes, types and codes.
// Used by every design file except spte_ram; depends on nothing.
package spte_pkg;

  localparam int Dims         = 4096;
  localparam int TopK         = 29;
  localparam int FeatCnt      = 6;
  localparam int ValueWidth   = 16;
  localparam int RowWidth     = 12;
  localparam int RankWidth    = 5;
  localparam int ScoreWidth   = 34;
  localparam int AccWidth     = 35;
  localparam int FloorWidth   = 18;
  localparam int DimsUseWidth = 13;
  localparam int CfgIdxWidth  = 1;
  localparam int CfgDataWidth = 18;
  localparam int ProdWidth    = 2 * ValueWidth;
  localparam int RowWordWidth = FeatCnt * ValueWidth;
  localparam int QueueDepth   = 2;

  localparam logic [FloorWidth-1:0]   FloorReset = 18'sh3FF9C;
  localparam logic [DimsUseWidth-1:0] DimsReset  = 13'd2880;

  typedef enum logic [0:0] {
    ActLoad   = 1'b0,
    ActEncode = 1'b1
  } action_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgFloor = 1'b0,
    CfgDims  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [0:0]               action;
    logic [RowWidth-1:0]      row;
    logic [RowWordWidth-1:0]  values;
  } cmd_t;

  typedef struct packed {
    logic [RankWidth-1:0]  rank;
    logic [RowWidth-1:0]   dim_index;
    logic [ScoreWidth-1:0] score;
    logic                  last;
  } res_t;

endpackage

// ----- design/spte_if.sv -----
// Channel interfaces for the encoder: command in, result out.
// Depends on spte_pkg.
interface spte_in_if;
  logic                               valid;
  logic                               ready;
  logic [0:0]                         action;
  logic [spte_pkg::RowWidth-1:0]      row;
  logic [spte_pkg::ValueWidth-1:0]    value_0;
  logic [spte_pkg::ValueWidth-1:0]    value_1;
  logic [spte_pkg::ValueWidth-1:0]    value_2;
  logic [spte_pkg::ValueWidth-1:0]    value_3;
  logic [spte_pkg::ValueWidth-1:0]    value_4;
  logic [spte_pkg::ValueWidth-1:0]    value_5;
  modport source (output valid, action, row, value_0, value_1, value_2, value_3, value_4,
                  value_5, input ready);
  modport sink (input valid, action, row, value_0, value_1, value_2, value_3, value_4,
                value_5, output ready);
endinterface

interface spte_out_if;
  logic                               valid;
  logic                               ready;
  logic [spte_pkg::RankWidth-1:0]     rank;
  logic [spte_pkg::RowWidth-1:0]      dim_index;
  logic [spte_pkg::ScoreWidth-1:0]    score;
  logic                               last;
  modport source (output valid, rank, dim_index, score, last, input ready);
  modport sink (input valid, rank, dim_index, score, last, output ready);
endinterface

// ----- design/sparse_projection_topk_encoder.sv -----
// Top level of the sparse projection top-K encoder.
// Depends on spte_pkg, spte_if, spte_front and spte_back.
//
// Usage: in_ch carries command beats. action 0 loads six signed weights into
// row "row" of the weight store; action 1 encodes six signed features.
// An encode walks dims_in_use rows (capped at 4096) through the weight RAM,
// one row per cycle, limited by the single RAM port, and keeps the top 29
// (score, row) pairs. It then sends 29 result beats on out_ch, rank 0 first,
// last set on rank 28. A load writes a single row of the weight store.
// A two-entry queue accepts command beats while the back end is busy.
// If the receiver stalls, the current result beat holds and the walk
// of later commands waits.
// The config port writes score_floor (index 0) and dims_in_use (index 1).
// Reset restores -100 and 2880, clears the list rows to zero and empties
// the queue; the weight store is undefined until written.
module sparse_projection_topk_encoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [spte_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [spte_pkg::CfgDataWidth-1:0]    cfg_data_i,
  spte_in_if.sink                              in_ch,
  spte_out_if.source                           out_ch
);
  logic [spte_pkg::FloorWidth-1:0]   floor_q;
  logic [spte_pkg::DimsUseWidth-1:0] dims_q;
  spte_pkg::cmd_t in_cmd, q_cmd;
  spte_pkg::res_t res;
  logic q_valid, q_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= spte_pkg::FloorReset;
      dims_q  <= spte_pkg::DimsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spte_pkg::CfgFloor: floor_q <= cfg_data_i;
        spte_pkg::CfgDims:  dims_q  <= cfg_data_i[spte_pkg::DimsUseWidth-1:0];
        default: ;
      endcase
    end
  end

  assign in_cmd.action = in_ch.action;
  assign in_cmd.row    = in_ch.row;
  assign in_cmd.values = {in_ch.value_5, in_ch.value_4, in_ch.value_3,
                          in_ch.value_2, in_ch.value_1, in_ch.value_0};

  spte_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(in_ch.valid), .ready_o(in_ch.ready),
    .cmd_i(in_cmd), .cmd_valid_o(q_valid), .cmd_pop_i(q_pop), .cmd_o(q_cmd)
  );

  spte_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_valid_i(q_valid), .cmd_pop_o(q_pop),
    .cmd_i(q_cmd), .floor_i(floor_q), .dims_i(dims_q),
    .res_valid_o(out_ch.valid), .res_ready_i(out_ch.ready), .res_o(res)
  );

  assign out_ch.rank      = res.rank;
  assign out_ch.dim_index = res.dim_index;
  assign out_ch.score     = res.score;
  assign out_ch.last      = res.last;
endmodule

// ----- design/spte_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module spte_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One access a cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- design/spte_front.sv -----
// Front end: accepts command beats into a short queue for the back end.
// Depends on spte_pkg.
module spte_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  spte_pkg::cmd_t    cmd_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output spte_pkg::cmd_t    cmd_o
);
  spte_pkg::cmd_t slot_q [spte_pkg::QueueDepth];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push;

  assign ready_o     = (cnt_q != 2'd2);
  assign push        = valid_i && ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rp_q];

  // Payload slots.
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= cmd_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (cmd_pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end
endmodule

// ----- design/spte_back.sv -----
// Back end: weight store writes, row walk with dot product and top-K insert, result output.
// Depends on spte_pkg and spte_ram.
module spte_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  output logic                               cmd_pop_o,
  input  spte_pkg::cmd_t                     cmd_i,
  input  logic [spte_pkg::FloorWidth-1:0]    floor_i,
  input  logic [spte_pkg::DimsUseWidth-1:0]  dims_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output spte_pkg::res_t                     res_o
);
  localparam int K  = spte_pkg::TopK;
  localparam int VW = spte_pkg::ValueWidth;
  localparam int AW = spte_pkg::AccWidth;
  localparam int RW = spte_pkg::RowWidth;
  localparam int RankWidthL = spte_pkg::RankWidth;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StClear = 5'b00010,
    StWalk  = 5'b00100,
    StDrain = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [RW:0]              walk_q;      // rows issued
  logic [RW:0]              limit_q;
  logic [RW-1:0]            rd_row;
  logic [VW-1:0]            feat_q [spte_pkg::FeatCnt];
  logic                     v1_q, v2_q, v3_q;
  logic [RW-1:0]            r1_q, r2_q, r3_q;
  logic [spte_pkg::RowWordWidth-1:0] rdata;
  logic signed [spte_pkg::ProdWidth-1:0] prod_q [spte_pkg::FeatCnt];
  logic signed [AW-1:0]     s3_q;
  logic signed [AW-1:0]     ts_q [K];
  logic [RW-1:0]            tr_q [K];
  logic [K-1:0]             gt;
  logic [RankWidthL-1:0]    rank_q;
  logic                     ram_we;
  logic [RW-1:0]            ram_addr;

  assign ram_we   = (state_q == StIdle) && cmd_valid_i && (cmd_i.action == spte_pkg::ActLoad);
  assign rd_row   = walk_q[RW-1:0];
  assign ram_addr = ram_we ? cmd_i.row : rd_row;

  // One memory row holds all weights of a projection row.
  spte_ram #(.Width(spte_pkg::RowWordWidth), .Depth(spte_pkg::Dims)) u_wram (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(cmd_i.values), .rdata_o(rdata)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      StIdle: if (cmd_valid_i) begin
        cmd_pop_o = 1'b1;
        if (cmd_i.action == spte_pkg::ActEncode) state_d = StClear;
      end
      StClear: state_d = (limit_q == '0) ? StDrain : StWalk;
      StWalk:  if (walk_q + 1'b1 >= limit_q) state_d = StDrain;
      StDrain: if (!v1_q && !v2_q && !v3_q) state_d = StEmit;
      StEmit:  if (res_ready_i && rank_q == RankWidthL'(K - 1)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      rank_q <= '0; walk_q <= '0; limit_q <= '0;
      for (int i = 0; i < K; i++) tr_q[i] <= '0;
    end else begin
      state_q <= state_d;
      // Read issue then multiply then sum, one row per cycle.
      v1_q <= (state_q == StWalk);
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (state_q == StIdle && cmd_valid_i) begin
        walk_q  <= '0;
        limit_q <= (dims_i > spte_pkg::DimsUseWidth'(spte_pkg::Dims))
                   ? (RW+1)'(spte_pkg::Dims) : dims_i[RW:0];
        rank_q  <= '0;
      end
      if (state_q == StWalk) walk_q <= walk_q + 1'b1;
      if (state_q == StEmit && res_ready_i) rank_q <= rank_q + 1'b1;
      if (v3_q) begin
        for (int i = 0; i < K; i++) begin
          if (gt[i]) begin
            if (i == 0 || !gt[i == 0 ? 0 : i-1]) tr_q[i] <= r3_q;
            else tr_q[i] <= tr_q[i == 0 ? 0 : i-1];
          end
        end
      end
    end
  end

  // Strict compare per slot; the list is sorted so gt is a thermometer.
  always_comb begin
    for (int i = 0; i < K; i++) gt[i] = (s3_q > ts_q[i]);
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i) begin
      for (int j = 0; j < spte_pkg::FeatCnt; j++) feat_q[j] <= cmd_i.values[j*VW +: VW];
    end
    r1_q <= rd_row; r2_q <= r1_q; r3_q <= r2_q;
    for (int j = 0; j < spte_pkg::FeatCnt; j++)
      prod_q[j] <= $signed(feat_q[j]) * $signed(rdata[j*VW +: VW]);
    s3_q <= AW'(prod_q[0]) + AW'(prod_q[1]) + AW'(prod_q[2]) +
            AW'(prod_q[3]) + AW'(prod_q[4]) + AW'(prod_q[5]);
    if (state_q == StClear) begin
      for (int i = 0; i < K; i++) ts_q[i] <= AW'($signed(floor_i));
    end else if (v3_q) begin
      for (int i = 0; i < K; i++) begin
        if (gt[i]) begin
          if (i == 0 || !gt[i == 0 ? 0 : i-1]) ts_q[i] <= s3_q;
          else ts_q[i] <= ts_q[i == 0 ? 0 : i-1];
        end
      end
    end
  end

  // Results read straight from the list.
  assign res_valid_o     = (state_q == StEmit);
  assign res_o.rank      = rank_q;
  assign res_o.dim_index = tr_q[rank_q];
  assign res_o.score     = ts_q[rank_q][spte_pkg::ScoreWidth-1:0];
  assign res_o.last      = (rank_q == RankWidthL'(K - 1));
endmodule

// ----- design/spte_checker.sv -----
// Port-level checker for the encoder, bound to the top level.
// Depends on spte_pkg.
module spte_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [spte_pkg::RankWidth-1:0]     out_rank_i,
  input logic                               out_last_i
);
  // Last is flagged exactly on the final rank.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_rank_i == spte_pkg::RankWidth'(spte_pkg::TopK - 1))))
    else $error("last flag does not match rank");

  // Ranks advance by one after a taken non-final beat.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_last_i) |=>
      (out_valid_i && out_rank_i == $past(out_rank_i) + 1'b1))
    else $error("rank did not advance");

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_rank_i)))
    else $error("stalled beat changed");
endmodule

bind sparse_projection_topk_encoder spte_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
  .out_rank_i(out_ch.rank), .out_last_i(out_ch.last)
);
